// ===== hw/rtl/scm_pkg.sv =====
// ---------------------------------------------------------------------------
// scm_pkg: shared types, constants and saturating helpers
// Signed Q16.32 arithmetic used by the series-capacitor step engine.
// ---------------------------------------------------------------------------
package scm_pkg;

  localparam int SIG_W        = 48;
  localparam int REG_W        = 47;
  localparam int FRAC_W       = 32;
  localparam int MAX_PTS      = 11;
  localparam int CIDX_W       = $clog2(MAX_PTS);
  localparam int PTS_W        = 4;
  localparam int MUL_DIGIT    = 16;
  localparam int MUL_STEPS    = SIG_W / MUL_DIGIT;
  localparam int MUL_CNT_W    = $clog2(MUL_STEPS);
  localparam int DIV_STEPS    = FRAC_W + REG_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W    = 3;

  typedef logic signed [SIG_W-1:0] sig_t;

  localparam sig_t SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam sig_t SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};
  localparam sig_t LIM700  = sig_t'(64'd700 << FRAC_W);

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TIME   = 3'd0,
    CFG_INV_IND     = 3'd1,
    CFG_SER_RES     = 3'd2,
    CFG_STEP_OVER_C = 3'd3,
    CFG_DAMP_SCALE  = 3'd4,
    CFG_OPEN_THR    = 3'd5,
    CFG_MOV_EN      = 3'd6,
    CFG_CURVE_PTS   = 3'd7
  } cfg_idx_t;

  // item kinds
  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  // curve scan result
  typedef struct packed {
    logic done;
    logic use_seg;
    sig_t base_v;
    sig_t cur;
    sig_t slope;
  } curve_res_t;

  function automatic sig_t sat_add(sig_t a, sig_t b);
    logic signed [SIG_W:0] s;
    s = {a[SIG_W-1], a} + {b[SIG_W-1], b};
    if (s[SIG_W] != s[SIG_W-1]) return s[SIG_W] ? SIG_MIN : SIG_MAX;
    return s[SIG_W-1:0];
  endfunction

  function automatic sig_t sat_neg(sig_t a);
    return (a == SIG_MIN) ? SIG_MAX : -a;
  endfunction

  function automatic sig_t sat_sub(sig_t a, sig_t b);
    return sat_add(a, sat_neg(b));
  endfunction

  function automatic logic [SIG_W-1:0] mag(sig_t a);
    return a[SIG_W-1] ? (~a + 1'b1) : a;
  endfunction

endpackage

// ===== hw/rtl/scm_ram.sv =====
// ---------------------------------------------------------------------------
// scm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module scm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/scm_mul.sv =====
// ---------------------------------------------------------------------------
// scm_mul: shared Q16.32 multiplier
// Magnitude product over 16-bit digits, then round half away and saturate.
// ---------------------------------------------------------------------------
module scm_mul import scm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sig_t a,
  input  sig_t b,
  output logic done,
  output sig_t res
);

  logic [SIG_W-1:0]   mx, my;
  logic [2*SIG_W-1:0] acc;
  logic [MUL_CNT_W-1:0] cnt;
  logic               run, rnd, neg;
  logic [63:0]        pp;
  logic [2*SIG_W-1:0] acc_rnd;
  logic [63:0]        r;

  assign pp      = {{(64-SIG_W){1'b0}}, mx} * {48'b0, my[SIG_W-1 -: MUL_DIGIT]};
  assign acc_rnd = acc + (2*SIG_W)'(64'd1 << (FRAC_W - 1));
  assign r       = acc_rnd[2*SIG_W-1 -: 64];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      rnd  <= 1'b0;
      done <= 1'b0;
    end else begin
      // saturate cycle follows the last digit, done follows the saturate cycle
      done <= rnd;
      rnd  <= run && !start && (cnt == MUL_CNT_W'(MUL_STEPS - 1));
      if (start) begin
        mx  <= mag(a);
        my  <= mag(b);
        neg <= a[SIG_W-1] ^ b[SIG_W-1];
        acc <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        // shift-add one digit of my per cycle, top digit first
        acc <= (acc << MUL_DIGIT) + (2*SIG_W)'(pp);
        my  <= my << MUL_DIGIT;
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
          run <= 1'b0;
        end
      end else if (rnd) begin
        // round already applied, now saturate
        if (neg) begin
          res <= (r >= 64'(SIG_MAX) + 64'd1) ? SIG_MIN : -sig_t'(r[SIG_W-1:0]);
        end else begin
          res <= (r >= 64'(SIG_MAX)) ? SIG_MAX : sig_t'(r[SIG_W-1:0]);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/scm_div.sv =====
// ---------------------------------------------------------------------------
// scm_div: restoring divider for the damping quotient
// Q16.32 quotient of two unsigned values, one bit per cycle, saturating.
// ---------------------------------------------------------------------------
module scm_div import scm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [REG_W-1:0] num,
  input  logic [REG_W-1:0] den,
  output logic             done,
  output sig_t             quo
);

  logic [DIV_STEPS-1:0] nreg;
  logic [REG_W-1:0]     rem, dreg, q;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy, ovf, dz;
  logic [REG_W:0]       r2;
  logic                 fits;

  assign r2   = {rem, nreg[DIV_STEPS-1]};
  assign fits = r2 >= {1'b0, dreg};
  assign quo  = (dz || ovf) ? SIG_MAX : {1'b0, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      nreg <= {num, {FRAC_W{1'b0}}};
      dreg <= den;
      rem  <= '0;
      q    <= '0;
      ovf  <= 1'b0;
      cnt  <= '0;
      dz   <= (den == '0);
      busy <= (den != '0);
      done <= (den == '0);
    end else if (busy) begin
      // one quotient bit per cycle; bits beyond the range flag overflow
      nreg <= nreg << 1;
      rem  <= fits ? REG_W'(r2 - {1'b0, dreg}) : r2[REG_W-1:0];
      q    <= {q[REG_W-2:0], fits};
      ovf  <= ovf | q[REG_W-1];
      cnt  <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/scm_curve.sv =====
// ---------------------------------------------------------------------------
// scm_curve: varistor curve table and segment scan
// Holds breakpoints in RAM and scans them one entry per cycle.
// ---------------------------------------------------------------------------
module scm_curve import scm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [CIDX_W-1:0] wr_idx,
  input  sig_t              wr_v,
  input  sig_t              wr_c,
  input  sig_t              wr_s,
  input  logic              start,
  input  sig_t              vmag,
  input  logic [CIDX_W-1:0] last,
  output curve_res_t        res
);

  logic [3*SIG_W-1:0] rdata;
  logic [CIDX_W-1:0]  cnt, didx;
  logic               busy, dvalid, found, lt0, gt_last, done;
  sig_t               rv, rc, rs;
  sig_t               pv, pc, ps;
  sig_t               sv, sc, ss;
  sig_t               c0, c_last, v_in;

  scm_ram #(.WIDTH(3*SIG_W), .DEPTH(MAX_PTS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata ({wr_v, wr_c, wr_s}),
    .raddr (cnt),
    .rdata (rdata)
  );

  assign {rv, rc, rs} = rdata;

  // scan: entry 0, then first upper breakpoint at or above the voltage
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      dvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      dvalid <= busy;
      didx   <= cnt;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        done  <= 1'b0;
        found <= 1'b0;
        v_in  <= vmag;
      end else if (busy) begin
        if (cnt == last) busy <= 1'b0;
        else cnt <= cnt + 1'b1;
      end
      if (dvalid) begin
        pv <= rv;
        pc <= rc;
        ps <= rs;
        if (didx == '0) begin
          c0  <= rc;
          lt0 <= v_in < rv;
        end else if (!found && v_in <= rv) begin
          found <= 1'b1;
          sv    <= pv;
          sc    <= pc;
          ss    <= ps;
        end
        if (didx == last) begin
          gt_last <= v_in > rv;
          c_last  <= rc;
          done    <= 1'b1;
        end
      end
    end
  end

  assign res.done    = done;
  assign res.use_seg = !gt_last && !lt0;
  assign res.base_v  = sv;
  assign res.cur     = res.use_seg ? sc : (gt_last ? c_last : c0);
  assign res.slope   = ss;

endmodule

// ===== hw/rtl/series_capacitor_mov_sim_step_top.sv =====
// ---------------------------------------------------------------------------
// series_capacitor_mov_sim_step_top: series-capacitor plant step engine
// Insertion logic, flux and capacitor integration and varistor curve,
// sequenced over one shared multiplier, a divider and a curve scanner.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_ready   kind, enable, currents, ...
//   out       source     out_valid / out_ready output_current ... inserted
//   cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A curve write item is taken without leaving idle; a bypassed step goes
// straight to the output state. An inserted step runs the damping divide
// alongside the drive, flux and first inductor multiplier passes, then the
// damping, varistor (on a curve segment only) and capacitor passes; a zero
// frequency makes the divide finish at once.
// Synchronous reset clears all plant state; curve RAM is not cleared.
// in_ready is high only while the sequencer is idle; a finished item waits
// in the output register while the next item is taken.
// ---------------------------------------------------------------------------
module series_capacitor_mov_sim_step_top import scm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  logic                 enable,
  input  sig_t                 line_current,
  input  sig_t                 input_voltage,
  input  sig_t                 output_voltage,
  input  logic [REG_W-1:0]     electrical_frequency,
  input  logic [PTS_W-1:0]     point_index,
  input  logic [REG_W-1:0]     point_voltage,
  input  sig_t                 point_current,
  input  sig_t                 point_slope,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sig_t                 output_current,
  output sig_t                 bypass_current,
  output sig_t                 capacitor_voltage,
  output sig_t                 varistor_current,
  output sig_t                 inductor_current,
  output logic                 inserted,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MDRV = 8'b0000_0010,
    S_MFLX = 8'b0000_0100,
    S_MIL1 = 8'b0000_1000,
    S_MIL2 = 8'b0001_0000,
    S_MMOV = 8'b0010_0000,
    S_MCAP = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state;

  // config registers
  logic [REG_W-1:0] step_time, inv_ind, ser_res, step_over_c, damp_scale, open_thr;
  logic             mov_en;
  logic [PTS_W-1:0] curve_pts;

  // plant state and work registers
  logic ins, issued, vneg;
  sig_t bypass_now, bypass_before, flux, coil, cap, imov, drive, tmp;
  sig_t vin_r, vout_r, vmag_r;

  logic       in_acc, step_acc, low_cur, flip, ins_next;
  logic       mul_start, mul_done, div_done;
  sig_t       mul_a, mul_b, mul_res, rhf, cap_mag, cap_sub, mov_r;
  logic [CIDX_W-1:0] last_idx;
  curve_res_t cres;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign step_acc  = in_acc && (kind == KIND_STEP);

  // insertion decision
  assign low_cur  = mag(bypass_now) < {1'b0, open_thr};
  assign flip     = (bypass_now[SIG_W-1] && !bypass_before[SIG_W-1] && bypass_before != '0) ||
                    (!bypass_now[SIG_W-1] && bypass_now != '0 && bypass_before[SIG_W-1]);
  assign ins_next = enable && (ins || low_cur || flip);

  assign cap_mag = cap[SIG_W-1] ? sat_neg(cap) : cap;
  assign cap_sub = sat_sub(cap, mul_res);

  // curve point count clamped to the table
  always_comb begin
    if (curve_pts < PTS_W'(2))            last_idx = CIDX_W'(1);
    else if (curve_pts > PTS_W'(MAX_PTS)) last_idx = CIDX_W'(MAX_PTS - 1);
    else                                  last_idx = CIDX_W'(curve_pts - 1'b1);
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time   <= '0;
      inv_ind     <= '0;
      ser_res     <= '0;
      step_over_c <= '0;
      damp_scale  <= '0;
      open_thr    <= '0;
      mov_en      <= 1'b0;
      curve_pts   <= PTS_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP_TIME:   step_time   <= cfg_data;
        CFG_INV_IND:     inv_ind     <= cfg_data;
        CFG_SER_RES:     ser_res     <= cfg_data;
        CFG_STEP_OVER_C: step_over_c <= cfg_data;
        CFG_DAMP_SCALE:  damp_scale  <= cfg_data;
        CFG_OPEN_THR:    open_thr    <= cfg_data;
        CFG_MOV_EN:      mov_en      <= cfg_data[0];
        CFG_CURVE_PTS:   curve_pts   <= cfg_data[PTS_W-1:0];
        default: ;
      endcase
    end
  end

  scm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (step_acc && ins_next),
    .num   (damp_scale),
    .den   (electrical_frequency),
    .done  (div_done),
    .quo   (rhf)
  );

  scm_curve u_curve (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (in_acc && kind == KIND_POINT && point_index < PTS_W'(MAX_PTS)),
    .wr_idx (point_index[CIDX_W-1:0]),
    .wr_v   ({1'b0, point_voltage}),
    .wr_c   (point_current),
    .wr_s   (point_slope),
    .start  (step_acc && ins_next && mov_en),
    .vmag   (cap_mag),
    .last   (last_idx),
    .res    (cres)
  );

  scm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // multiplier operand select per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MDRV: begin mul_a = {1'b0, ser_res};   mul_b = coil; end
      S_MFLX: begin mul_a = {1'b0, step_time}; mul_b = drive; end
      S_MIL1: begin mul_a = flux;              mul_b = {1'b0, inv_ind}; end
      S_MIL2: begin mul_a = drive;             mul_b = rhf; end
      S_MMOV: begin mul_a = cres.slope;        mul_b = sat_sub(vmag_r, cres.base_v); end
      S_MCAP: begin mul_a = sat_add(coil, imov); mul_b = {1'b0, step_over_c}; end
      default: ;
    endcase
  end

  // start once per multiply state, after its prerequisite is ready
  always_comb begin
    mul_start = 1'b0;
    if (!issued) begin
      unique case (state)
        S_MDRV, S_MFLX, S_MIL1, S_MCAP: mul_start = 1'b1;
        S_MIL2: mul_start = div_done;
        S_MMOV: mul_start = cres.done && cres.use_seg;
        default: ;
      endcase
    end
  end

  assign mov_r = sat_add(cres.use_seg ? cres.cur : '0, cres.use_seg ? mul_res : cres.cur);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      issued        <= 1'b0;
      ins           <= 1'b0;
      bypass_now    <= '0;
      bypass_before <= '0;
      flux          <= '0;
      coil          <= '0;
      cap           <= '0;
      imov          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_ready && state != S_FIN) out_valid <= 1'b0;
      if (mul_start) issued <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (step_acc) begin
            ins           <= ins_next;
            bypass_before <= bypass_now;
            imov          <= '0;
            issued        <= 1'b0;
            vin_r         <= input_voltage;
            vout_r        <= output_voltage;
            vmag_r        <= cap_mag;
            vneg          <= cap[SIG_W-1];
            if (ins_next) begin
              bypass_now <= '0;
              state      <= S_MDRV;
            end else begin
              bypass_now <= line_current;
              flux       <= '0;
              cap        <= '0;
              coil       <= '0;
              state      <= S_FIN;
            end
          end
        end
        S_MDRV: if (mul_done) begin
          drive  <= sat_sub(sat_sub(sat_add(vout_r, cap), vin_r), mul_res);
          issued <= 1'b0;
          state  <= S_MFLX;
        end
        S_MFLX: if (mul_done) begin
          flux   <= sat_add(flux, mul_res);
          issued <= 1'b0;
          state  <= S_MIL1;
        end
        S_MIL1: if (mul_done) begin
          tmp    <= mul_res;
          issued <= 1'b0;
          state  <= S_MIL2;
        end
        S_MIL2: if (mul_done) begin
          coil   <= sat_add(tmp, mul_res);
          issued <= 1'b0;
          state  <= mov_en ? S_MMOV : S_MCAP;
        end
        S_MMOV: begin
          // outside-curve points need no multiply
          if (cres.done && (mul_done || !cres.use_seg)) begin
            imov   <= vneg ? sat_neg(mov_r) : mov_r;
            issued <= 1'b0;
            state  <= S_MCAP;
          end
        end
        S_MCAP: if (mul_done) begin
          if (cap_sub > LIM700)       cap <= LIM700;
          else if (cap_sub < -LIM700) cap <= -LIM700;
          else                        cap <= cap_sub;
          issued <= 1'b0;
          state  <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            output_current    <= ins ? coil : bypass_now;
            bypass_current    <= bypass_now;
            capacitor_voltage <= cap;
            varistor_current  <= imov;
            inductor_current  <= coil;
            inserted          <= ins;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // capacitor voltage never leaves the clamp window
  a_cap_clamp: assert property (@(posedge clk) disable iff (rst)
    (cap <= LIM700) && (cap >= -LIM700))
    else $error("capacitor voltage outside clamp");

  // a bypassed branch holds no energy
  a_bypass_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !ins) |-> (cap == '0 && coil == '0 && flux == '0))
    else $error("bypassed branch state not cleared");

  // damping multiply only after the quotient is ready
  a_div_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIL2 && mul_start) |-> div_done)
    else $error("damping multiply before divide done");

  // inserted step never shows bypass current
  a_ins_bypass: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && ins) |-> (bypass_now == '0))
    else $error("bypass current while inserted");

endmodule
